FILE: design/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// shared types and codes of the sliding window median filter
// ----------------------------------------------------------------------------
package swm_pkg;

    localparam int SAMPLE_W = 32;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // action codes of an input word
    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_FILL = 1'b1;

    // source of a word written back to the rank memory
    typedef enum logic [1:0] {
        WR_HOLD,
        WR_NEW,
        WR_DAT
    } t_wr_src;

    // merge decision for one cycle of the rank walk
    typedef struct packed {
        logic    wr_en;
        t_wr_src wr_src;
        logic    hold_vld;
        logic    hold_load;
        logic    ins_set;
    } t_merge_ctl;

endpackage
`default_nettype wire

FILE: design/sliding_window_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median
// running median over the last MAX_INDEX+1 unsigned 32-bit samples
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake          payload
//  input     in         i_valid / o_ready  i_action, i_sample
//  result    out        o_valid / i_ready  o_median
//
//  one word in flight; from one accept to the next a sample word walks
//  MAX_INDEX+1 ranks through the single read port of the rank memory,
//  then drains, flushes, loads the result and returns to idle
//  a fill word writes all MAX_INDEX+1 ranks, one rank memory write per cycle
//  after reset a clearing pass writes the zero window to all MAX_INDEX+1
//  ranks; o_ready stays low during it
//  a waiting result does not stop the next accept; only the load of the
//  following result waits for i_ready
//
// the window is kept as one memory indexed by rank: each word holds the
// value and the slot it came from. a sample word walks the ranks in order,
// drops the oldest slot, inserts the new sample ahead of the first larger
// value and writes the merged order back in place. the median is caught
// as the word written at the middle rank passes by.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int MAX_INDEX = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic             i_action,
    input  wire swm_pkg::t_sample i_sample,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output swm_pkg::t_sample      o_median
);
    import swm_pkg::*;

    localparam int WIN_LEN = MAX_INDEX + 1;
    localparam int SLOT_W  = $clog2(WIN_LEN);
    localparam int ENT_W   = SLOT_W + SAMPLE_W;
    localparam logic [SLOT_W-1:0] LAST_RANK = SLOT_W'(MAX_INDEX);
    localparam logic [SLOT_W-1:0] MED_RANK  = SLOT_W'(MAX_INDEX / 2);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_FILL,
        ST_SCAN,
        ST_FLUSH,
        ST_DONE
    } t_state;

    // control and working registers
    t_state            r_state, n_state;
    logic [SLOT_W-1:0] r_fill_idx, n_fill_idx;
    logic [SLOT_W-1:0] r_rd_idx, n_rd_idx;
    logic [SLOT_W-1:0] r_wr_idx, n_wr_idx;
    logic [SLOT_W-1:0] r_oldest, n_oldest;
    logic              r_issue_done, n_issue_done;
    logic              r_dat_vld, n_dat_vld;
    logic              r_dat_last, n_dat_last;
    logic              r_hold_vld, n_hold_vld;
    logic              r_inserted, n_inserted;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_hold_slot, n_hold_slot;
    t_sample           r_hold_val, n_hold_val;
    t_sample           r_sample, n_sample;
    t_sample           r_med, n_med;
    t_sample           r_median, n_median;

    // rank memory
    logic [ENT_W-1:0]  mem [WIN_LEN];
    logic [ENT_W-1:0]  r_rd_q;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    logic [ENT_W-1:0]  mem_wdata;

    logic [SLOT_W-1:0] dat_slot;
    t_sample           dat_val;
    logic              issue;
    t_merge_ctl        m_ctl;

    assign dat_slot = r_rd_q[SAMPLE_W +: SLOT_W];
    assign dat_val  = r_rd_q[SAMPLE_W-1:0];
    assign issue    = !r_issue_done;

    swm_merge #(
        .SLOT_W (SLOT_W)
    ) u_merge (
        .i_dat_vld  (r_state == ST_SCAN && r_dat_vld),
        .i_flush    (r_state == ST_FLUSH),
        .i_dat_slot (dat_slot),
        .i_dat_val  (dat_val),
        .i_oldest   (r_oldest),
        .i_sample   (r_sample),
        .i_hold_vld (r_hold_vld),
        .i_inserted (r_inserted),
        .o_ctl      (m_ctl)
    );

    always_comb begin
        n_state      = r_state;
        n_fill_idx   = r_fill_idx;
        n_rd_idx     = r_rd_idx;
        n_wr_idx     = r_wr_idx;
        n_oldest     = r_oldest;
        n_issue_done = r_issue_done;
        n_dat_vld    = 1'b0;
        n_dat_last   = 1'b0;
        n_hold_vld   = r_hold_vld;
        n_inserted   = r_inserted;
        n_hold_slot  = r_hold_slot;
        n_hold_val   = r_hold_val;
        n_sample     = r_sample;
        n_med        = r_med;
        n_median     = r_median;
        n_out_valid  = r_out_valid && !i_ready;
        mem_we       = 1'b0;
        mem_waddr    = r_wr_idx;
        mem_wdata    = {r_oldest, r_sample};

        // write-back of the merged rank order
        if (r_state == ST_SCAN || r_state == ST_FLUSH) begin
            n_hold_vld = m_ctl.hold_vld;
            if (m_ctl.hold_load) begin
                n_hold_slot = dat_slot;
                n_hold_val  = dat_val;
            end
            if (m_ctl.ins_set) begin
                n_inserted = 1'b1;
            end
            if (m_ctl.wr_en) begin
                mem_we = 1'b1;
                case (m_ctl.wr_src)
                    WR_HOLD: mem_wdata = {r_hold_slot, r_hold_val};
                    WR_NEW:  mem_wdata = {r_oldest, r_sample};
                    WR_DAT:  mem_wdata = r_rd_q;
                    default: mem_wdata = r_rd_q;
                endcase
                n_wr_idx = r_wr_idx + SLOT_W'(1);
                // catch the middle rank as it is written
                if (r_wr_idx == MED_RANK) begin
                    n_med = mem_wdata[SAMPLE_W-1:0];
                end
            end
        end

        case (r_state)
            ST_INIT, ST_FILL: begin
                // identity order, every slot holds the fill value
                mem_we    = 1'b1;
                mem_waddr = r_fill_idx;
                mem_wdata = {r_fill_idx, r_sample};
                n_fill_idx = r_fill_idx + SLOT_W'(1);
                if (r_fill_idx == LAST_RANK) begin
                    n_fill_idx = '0;
                    n_oldest   = '0;
                    n_med      = r_sample;
                    n_state    = (r_state == ST_INIT) ? ST_IDLE : ST_DONE;
                end
            end
            ST_IDLE: begin
                if (i_valid) begin
                    n_sample     = i_sample;
                    n_rd_idx     = '0;
                    n_wr_idx     = '0;
                    n_fill_idx   = '0;
                    n_issue_done = 1'b0;
                    n_hold_vld   = 1'b0;
                    n_inserted   = 1'b0;
                    n_state      = (i_action == ACT_FILL) ? ST_FILL : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue) begin
                    // read address stays inside the window
                    n_rd_idx   = (r_rd_idx == LAST_RANK) ? '0 : r_rd_idx + SLOT_W'(1);
                    n_dat_vld  = 1'b1;
                    n_dat_last = (r_rd_idx == LAST_RANK);
                    if (r_rd_idx == LAST_RANK) begin
                        n_issue_done = 1'b1;
                    end
                end
                if (r_dat_vld && r_dat_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                n_oldest = (r_oldest == LAST_RANK) ? '0 : r_oldest + SLOT_W'(1);
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                // result register frees up or is taken this cycle
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_median    = r_med;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_INIT;
            r_fill_idx   <= '0;
            r_rd_idx     <= '0;
            r_wr_idx     <= '0;
            r_oldest     <= '0;
            r_issue_done <= 1'b0;
            r_dat_vld    <= 1'b0;
            r_dat_last   <= 1'b0;
            r_hold_vld   <= 1'b0;
            r_inserted   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_hold_slot  <= '0;
            r_hold_val   <= '0;
            r_sample     <= '0;
            r_med        <= '0;
            r_median     <= '0;
        end else begin
            r_state      <= n_state;
            r_fill_idx   <= n_fill_idx;
            r_rd_idx     <= n_rd_idx;
            r_wr_idx     <= n_wr_idx;
            r_oldest     <= n_oldest;
            r_issue_done <= n_issue_done;
            r_dat_vld    <= n_dat_vld;
            r_dat_last   <= n_dat_last;
            r_hold_vld   <= n_hold_vld;
            r_inserted   <= n_inserted;
            r_out_valid  <= n_out_valid;
            r_hold_slot  <= n_hold_slot;
            r_hold_val   <= n_hold_val;
            r_sample     <= n_sample;
            r_med        <= n_med;
            r_median     <= n_median;
        end
    end

    // rank memory: one write port, one registered read port (read-first)
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_q <= mem[r_rd_idx];
    end

    assign o_ready  = (r_state == ST_IDLE);
    assign o_valid  = r_out_valid;
    assign o_median = r_median;

endmodule
`default_nettype wire

FILE: design/swm_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_merge
// per-cycle decision of the rank walk: drop the oldest slot, insert the new
// sample ahead of the first larger value, keep the rest in order
// ----------------------------------------------------------------------------
module swm_merge #(
    parameter int SLOT_W = 3
) (
    input  wire logic              i_dat_vld,
    input  wire logic              i_flush,
    input  wire logic [SLOT_W-1:0] i_dat_slot,
    input  wire swm_pkg::t_sample  i_dat_val,
    input  wire logic [SLOT_W-1:0] i_oldest,
    input  wire swm_pkg::t_sample  i_sample,
    input  wire logic              i_hold_vld,
    input  wire logic              i_inserted,
    output swm_pkg::t_merge_ctl    o_ctl
);
    import swm_pkg::*;

    logic keep;
    logic ins_here;

    assign keep     = i_dat_vld && (i_dat_slot != i_oldest);
    assign ins_here = keep && !i_inserted && (i_sample < i_dat_val);

    always_comb begin
        o_ctl           = '0;
        o_ctl.wr_src    = WR_DAT;
        o_ctl.hold_vld  = i_hold_vld;
        if (i_flush) begin
            // last write: the held word, or the new sample if it goes last
            o_ctl.wr_en    = i_hold_vld || !i_inserted;
            o_ctl.wr_src   = i_hold_vld ? WR_HOLD : WR_NEW;
            o_ctl.hold_vld = 1'b0;
            o_ctl.ins_set  = 1'b1;
        end else if (i_dat_vld) begin
            if (i_hold_vld) begin
                // held word goes out, the read word waits behind it unless it is the oldest
                o_ctl.wr_en     = 1'b1;
                o_ctl.wr_src    = WR_HOLD;
                o_ctl.hold_vld  = keep;
                o_ctl.hold_load = keep;
            end else if (ins_here) begin
                o_ctl.wr_en     = 1'b1;
                o_ctl.wr_src    = WR_NEW;
                o_ctl.hold_vld  = 1'b1;
                o_ctl.hold_load = 1'b1;
                o_ctl.ins_set   = 1'b1;
            end else if (keep) begin
                o_ctl.wr_en  = 1'b1;
                o_ctl.wr_src = WR_DAT;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/swm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_checker
// port-level checks of the sliding window median filter
// ----------------------------------------------------------------------------
module swm_checker (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_valid,
    input wire logic             o_ready,
    input wire logic             i_action,
    input wire swm_pkg::t_sample i_sample,
    input wire logic             o_valid,
    input wire logic             i_ready,
    input wire swm_pkg::t_sample o_median
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_median))
        else $error("result word changed while stalled");

    // a waiting input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_action) && $stable(i_sample))
        else $error("input word changed while waiting");

    // one word in flight at a time
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while a word is in flight");

    // reset starts the clearing pass with no result pending
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_ready)
        else $error("reset left the block ready or a result pending");

    // a new result only appears while the block is busy
    a_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(!o_ready))
        else $error("result appeared while the block was idle");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_ready  (o_ready),
    .i_action (i_action),
    .i_sample (i_sample),
    .o_valid  (o_valid),
    .i_ready  (i_ready),
    .o_median (o_median)
);
`default_nettype wire
